// ----- rtl/assert_macros.svh -----
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bif_pkg.sv -----
// Types, constants and helper functions of the battery indicator fader.
package bif_pkg;

   localparam logic [19:0] MASK20      = 20'hFFFFF;
   localparam logic [8:0]  LATCH_RESET = 9'd169;
   localparam logic [7:0]  HUE_GREEN   = 8'd85;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIM,
      ST_PER,
      ST_STEPS,
      ST_FRAME,
      ST_VAL,
      ST_HUE,
      ST_DONE
   } bif_state_type;

   typedef enum logic [2:0] {
      CSR_LEVEL_EMPTY     = 3'd0,
      CSR_LEVEL_LOW       = 3'd1,
      CSR_LEVEL_FULL      = 3'd2,
      CSR_CHARGED_TIMEOUT = 3'd3,
      CSR_FADE_PERIOD     = 3'd4,
      CSR_DIM_MIN         = 3'd5,
      CSR_DIM_MAX         = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  level_empty;
      logic [7:0]  level_low;
      logic [7:0]  level_full;
      logic [19:0] full_hold_ms;
      logic [11:0] fade_period_ms;
      logic [7:0]  dim_min;
      logic [7:0]  dim_max;
   } cfg_type;

   // request to the shared multiply/divide unit: q = a * b / d
   typedef struct packed {
      logic        start;
      logic [7:0]  a;
      logic [11:0] b;
      logic [11:0] d;
   } mdu_req_type;

   typedef struct packed {
      logic        done;
      logic [19:0] q;
   } mdu_rsp_type;

   typedef struct packed {
      logic        load;
      logic [7:0]  icon_hue;
      logic [7:0]  icon_value;
      logic        low_battery;
      logic        dim_valid;
      logic [7:0]  dim_brightness;
   } res_type;

   typedef struct packed {
      logic        degen;
      logic [7:0]  num;
      logic [11:0] mag;
      logic        neg;
      logic [7:0]  den;
   } lin_type;

   // operands of a linear map; slope sign is split off so the divider stays unsigned
   function automatic lin_type lin_setup(input logic [8:0] x, input logic [7:0] lo,
                                         input logic [7:0] hi, input logic [11:0] olo,
                                         input logic [11:0] ohi);
      lin_type    r;
      logic [8:0] xc;
      xc = (x > {1'b0, hi}) ? {1'b0, hi} : x;
      if (xc < {1'b0, lo}) xc = {1'b0, lo};
      r.degen = (hi <= lo);
      r.num   = 8'(xc - {1'b0, lo});
      r.neg   = (ohi < olo);
      r.mag   = r.neg ? (olo - ohi) : (ohi - olo);
      r.den   = hi - lo;
      return r;
   endfunction

endpackage

// ----- rtl/bif_mul_div.sv -----
// Shared arithmetic unit: registered product, then restoring division one bit per cycle.
module bif_mul_div
   import bif_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mdu_req_type mdu_req,
   output mdu_rsp_type mdu_rsp
);

   localparam int NUM_W = 20;
   localparam int DIV_W = 12;
   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] work_ff, work_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] div_ff, div_in;
   logic [DIV_W:0]   rem_sh;
   logic             qbit;

   assign rem_sh = {rem_ff, work_ff[NUM_W-1]};
   assign qbit   = (rem_sh >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (!busy_ff) begin
         if (mdu_req.start) begin
            work_in = NUM_W'({12'd0, mdu_req.a} * {8'd0, mdu_req.b});
            div_in  = mdu_req.d;
            rem_in  = '0;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else begin
         rem_in  = qbit ? DIV_W'(rem_sh - {1'b0, div_ff}) : rem_sh[DIV_W-1:0];
         work_in = {work_ff[NUM_W-2:0], qbit};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign mdu_rsp.done = done_ff;
   assign mdu_rsp.q    = work_ff;

endmodule

// ----- rtl/bif_ctrl.sv -----
// Sequencer and tick state of the battery indicator fader.
module bif_ctrl
   import bif_pkg::*;
#(
   parameter int TICK_MS = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  battery_level,
   input  logic        charging,
   input  logic [7:0]  user_brightness,
   input  logic        out_free,
   output res_type     res,
   output mdu_req_type mdu_req,
   input  mdu_rsp_type mdu_rsp
);

   bif_state_type state_ff, state_in;
   logic        issued_ff, issued_in;
   logic [7:0]  level_ff, level_in;
   logic        charging_ff, charging_in;
   logic [7:0]  bright_ff, bright_in;
   logic [7:0]  charge_frames_ff, charge_frames_in;
   logic        charge_rising_ff, charge_rising_in;
   logic [7:0]  low_frames_ff, low_frames_in;
   logic        low_rising_ff, low_rising_in;
   logic [8:0]  latch_ff, latch_in;
   logic        at_full_ff, at_full_in;
   logic [19:0] full_time_ff, full_time_in;
   logic        low_flag_ff, low_flag_in;
   logic        dvalid_ff, dvalid_in;
   logic [7:0]  dbright_ff, dbright_in;
   logic [11:0] period_ff, period_in;
   logic [11:0] steps_ff, steps_in;
   logic [7:0]  value_ff, value_in;
   logic [7:0]  hue_ff, hue_in;

   lin_type     lin_hue, lin_dim, lin_per, lin_cur;
   logic [11:0] olo_cur, lin_res;
   logic [8:0]  low_plus;
   logic        at_full_new, fade_on, low_hit;
   logic [20:0] ft_sum;
   logic [19:0] ft_new;
   logic [8:0]  latch_new;
   logic [7:0]  f_frames, f_max;
   logic        f_rising;
   logic [11:0] f_period;
   logic        accept;

   assign accept = req_valid && req_ready;

   // tick bookkeeping
   assign low_plus    = {1'b0, cfg.level_low} + 9'd1;
   assign at_full_new = at_full_ff || (level_ff >= cfg.level_full);
   assign ft_sum      = {1'b0, full_time_ff} + 21'(TICK_MS);
   assign ft_new      = !at_full_new ? 20'd0 :
                        (ft_sum > {1'b0, MASK20}) ? MASK20 : ft_sum[19:0];
   assign fade_on     = (ft_new < cfg.full_hold_ms);
   assign latch_new   = ({1'b0, level_ff} < latch_ff) ? {1'b0, level_ff} : latch_ff;
   assign low_hit     = (latch_new <= {1'b0, cfg.level_low});

   // linear maps
   assign lin_hue = lin_setup({1'b0, level_ff}, cfg.level_empty, cfg.level_full,
                              12'd0, {4'd0, HUE_GREEN});
   assign lin_dim = lin_setup(latch_ff, cfg.level_empty, cfg.level_low,
                              {4'd0, cfg.dim_min}, {4'd0, cfg.dim_max});
   assign lin_per = lin_setup(latch_ff, cfg.level_empty, cfg.level_low,
                              {2'd0, cfg.fade_period_ms[11:2]}, cfg.fade_period_ms);

   always_comb begin
      case (state_ff)
         ST_DIM: begin
            lin_cur = lin_dim;
            olo_cur = {4'd0, cfg.dim_min};
         end
         ST_PER: begin
            lin_cur = lin_per;
            olo_cur = {2'd0, cfg.fade_period_ms[11:2]};
         end
         default: begin
            lin_cur = lin_hue;
            olo_cur = 12'd0;
         end
      endcase
   end

   assign lin_res = lin_cur.degen ? olo_cur :
                    lin_cur.neg   ? (olo_cur - mdu_rsp.q[11:0]) :
                                    (olo_cur + mdu_rsp.q[11:0]);

   // fade operands: charging breath or low-battery breath
   assign f_frames = charging_ff ? charge_frames_ff : low_frames_ff;
   assign f_rising = charging_ff ? charge_rising_ff : low_rising_ff;
   assign f_max    = charging_ff ? bright_ff : dbright_ff;
   assign f_period = charging_ff ? cfg.fade_period_ms : period_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (charging_ff) state_in = fade_on ? ST_STEPS : ST_HUE;
            else             state_in = low_hit ? ST_DIM : ST_HUE;
         end
         ST_DIM: begin
            if (lin_cur.degen || mdu_rsp.done) state_in = ST_PER;
         end
         ST_PER: begin
            if (lin_cur.degen || mdu_rsp.done) state_in = ST_STEPS;
         end
         ST_STEPS: begin
            if (mdu_rsp.done) state_in = ST_FRAME;
         end
         ST_FRAME: state_in = ST_VAL;
         ST_VAL: begin
            if (mdu_rsp.done) state_in = ST_HUE;
         end
         ST_HUE: begin
            if (lin_cur.degen || mdu_rsp.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and unit requests
   always_comb begin
      issued_in        = issued_ff;
      level_in         = level_ff;
      charging_in      = charging_ff;
      bright_in        = bright_ff;
      charge_frames_in = charge_frames_ff;
      charge_rising_in = charge_rising_ff;
      low_frames_in    = low_frames_ff;
      low_rising_in    = low_rising_ff;
      latch_in         = latch_ff;
      at_full_in       = at_full_ff;
      full_time_in     = full_time_ff;
      low_flag_in      = low_flag_ff;
      dvalid_in        = dvalid_ff;
      dbright_in       = dbright_ff;
      period_in        = period_ff;
      steps_in         = steps_ff;
      value_in         = value_ff;
      hue_in           = hue_ff;
      mdu_req          = '0;
      req_ready        = 1'b0;
      res              = '0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               level_in    = battery_level;
               charging_in = charging;
               bright_in   = user_brightness;
            end
         end
         ST_PREP: begin
            value_in   = bright_ff;
            dbright_in = 8'd0;
            dvalid_in  = 1'b0;
            if (charging_ff) begin
               if (latch_ff != low_plus) begin
                  latch_in    = low_plus;
                  low_flag_in = 1'b0;
               end
               at_full_in   = at_full_new;
               full_time_in = ft_new;
            end else begin
               at_full_in = 1'b0;
               latch_in   = latch_new;
               if (low_hit) begin
                  low_flag_in = 1'b1;
                  dvalid_in   = 1'b1;
               end
            end
         end
         ST_DIM, ST_PER, ST_HUE: begin
            mdu_req.a     = lin_cur.num;
            mdu_req.b     = lin_cur.mag;
            mdu_req.d     = {4'd0, lin_cur.den};
            mdu_req.start = !lin_cur.degen && !issued_ff;
            if (lin_cur.degen || mdu_rsp.done) begin
               case (state_ff)
                  ST_DIM:  dbright_in = lin_res[7:0];
                  ST_PER:  period_in  = lin_res;
                  default: hue_in     = lin_res[7:0];
               endcase
            end
         end
         ST_STEPS: begin
            mdu_req.a     = 8'd1;
            mdu_req.b     = f_period;
            mdu_req.d     = 12'(TICK_MS);
            mdu_req.start = !issued_ff;
            if (mdu_rsp.done) begin
               steps_in = (mdu_rsp.q == 20'd0) ? 12'd1 : mdu_rsp.q[11:0];
            end
         end
         ST_FRAME: begin
            // triangle: count down to zero, then up to the step count or 255
            if (!f_rising) begin
               if (f_frames == 8'd0) begin
                  if (charging_ff) charge_rising_in = 1'b1;
                  else             low_rising_in    = 1'b1;
               end else begin
                  if (charging_ff) charge_frames_in = f_frames - 8'd1;
                  else             low_frames_in    = f_frames - 8'd1;
               end
            end else begin
               if (({4'd0, f_frames} >= steps_ff) || (f_frames == 8'd255)) begin
                  if (charging_ff) charge_rising_in = 1'b0;
                  else             low_rising_in    = 1'b0;
               end else begin
                  if (charging_ff) charge_frames_in = f_frames + 8'd1;
                  else             low_frames_in    = f_frames + 8'd1;
               end
            end
         end
         ST_VAL: begin
            mdu_req.a     = f_max;
            mdu_req.b     = {4'd0, f_frames};
            mdu_req.d     = steps_ff;
            mdu_req.start = !issued_ff;
            if (mdu_rsp.done) begin
               value_in = (mdu_rsp.q > {12'd0, f_max}) ? f_max : mdu_rsp.q[7:0];
            end
         end
         ST_DONE: begin
            res.load = out_free;
         end
         default: ;
      endcase

      if (mdu_req.start)     issued_in = 1'b1;
      else if (mdu_rsp.done) issued_in = 1'b0;

      res.icon_hue       = hue_ff;
      res.icon_value     = value_ff;
      res.low_battery    = low_flag_ff;
      res.dim_valid      = dvalid_ff;
      res.dim_brightness = dbright_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         issued_ff        <= 1'b0;
         charge_frames_ff <= 8'd0;
         charge_rising_ff <= 1'b0;
         low_frames_ff    <= 8'd0;
         low_rising_ff    <= 1'b0;
         latch_ff         <= LATCH_RESET;
         at_full_ff       <= 1'b0;
         full_time_ff     <= 20'd0;
         low_flag_ff      <= 1'b0;
      end else begin
         state_ff         <= state_in;
         issued_ff        <= issued_in;
         charge_frames_ff <= charge_frames_in;
         charge_rising_ff <= charge_rising_in;
         low_frames_ff    <= low_frames_in;
         low_rising_ff    <= low_rising_in;
         latch_ff         <= latch_in;
         at_full_ff       <= at_full_in;
         full_time_ff     <= full_time_in;
         low_flag_ff      <= low_flag_in;
      end
      level_ff    <= level_in;
      charging_ff <= charging_in;
      bright_ff   <= bright_in;
      dvalid_ff   <= dvalid_in;
      dbright_ff  <= dbright_in;
      period_ff   <= period_in;
      steps_ff    <= steps_in;
      value_ff    <= value_in;
      hue_ff      <= hue_in;
   end

endmodule

// ----- rtl/battery_indicator_fader_top.sv -----
// Battery indicator fader: hue, breathing value and low-battery dimming per loop tick.
// Requests are taken one at a time: a new word is accepted only after the last result is loaded.
// All divisions run on the shared divider, one quotient bit per cycle while it is busy;
// a degenerate linear map skips its division.
// Result sits in an output register, so the next word is accepted while it waits.
// Synchronous active-high reset restores register defaults and the tick state.
`include "assert_macros.svh"

module battery_indicator_fader_top
   import bif_pkg::*;
#(
   parameter int TICK_MS = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_battery_level,
   input  logic        req_charging,
   input  logic [7:0]  req_user_brightness,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_icon_hue,
   output logic [7:0]  rsp_icon_value,
   output logic        rsp_low_battery,
   output logic        rsp_dim_valid,
   output logic [7:0]  rsp_dim_brightness,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   res_type     res;
   mdu_req_type mdu_req;
   mdu_rsp_type mdu_rsp;
   logic        out_free;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  hue_ff, hue_in;
   logic [7:0]  value_ff, value_in;
   logic        low_ff, low_in;
   logic        dvalid_ff, dvalid_in;
   logic [7:0]  dbright_ff, dbright_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_LEVEL_EMPTY:     cfg_in.level_empty    = csr_wdata[7:0];
            CSR_LEVEL_LOW:       cfg_in.level_low      = csr_wdata[7:0];
            CSR_LEVEL_FULL:      cfg_in.level_full     = csr_wdata[7:0];
            CSR_CHARGED_TIMEOUT: cfg_in.full_hold_ms   = csr_wdata;
            CSR_FADE_PERIOD:     cfg_in.fade_period_ms = csr_wdata[11:0];
            CSR_DIM_MIN:         cfg_in.dim_min        = csr_wdata[7:0];
            CSR_DIM_MAX:         cfg_in.dim_max        = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   bif_mul_div u_mul_div (
      .clock   (clock),
      .reset   (reset),
      .mdu_req (mdu_req),
      .mdu_rsp (mdu_rsp)
   );

   bif_ctrl #(
      .TICK_MS (TICK_MS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .battery_level   (req_battery_level),
      .charging        (req_charging),
      .user_brightness (req_user_brightness),
      .out_free        (out_free),
      .res             (res),
      .mdu_req         (mdu_req),
      .mdu_rsp         (mdu_rsp)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      hue_in       = hue_ff;
      value_in     = value_ff;
      low_in       = low_ff;
      dvalid_in    = dvalid_ff;
      dbright_in   = dbright_ff;
      if (res.load) begin
         rsp_valid_in = 1'b1;
         hue_in       = res.icon_hue;
         value_in     = res.icon_value;
         low_in       = res.low_battery;
         dvalid_in    = res.dim_valid;
         dbright_in   = res.dim_brightness;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_empty    <= 8'd163;
         cfg_ff.level_low      <= 8'd168;
         cfg_ff.level_full     <= 8'd214;
         cfg_ff.full_hold_ms   <= 20'd300000;
         cfg_ff.fade_period_ms <= 12'd500;
         cfg_ff.dim_min        <= 8'd10;
         cfg_ff.dim_max        <= 8'd15;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hue_ff     <= hue_in;
      value_ff   <= value_in;
      low_ff     <= low_in;
      dvalid_ff  <= dvalid_in;
      dbright_ff <= dbright_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_icon_hue       = hue_ff;
   assign rsp_icon_value     = value_ff;
   assign rsp_low_battery    = low_ff;
   assign rsp_dim_valid      = dvalid_ff;
   assign rsp_dim_brightness = dbright_ff;

   `ASSERT_IMPL(a_dim_needs_low, clock, reset, rsp_valid && dvalid_ff, low_ff, "dim w/o low")
   `ASSERT_IMPL(a_dim_zero, clock, reset, rsp_valid && !dvalid_ff, dbright_ff == '0, "dim set")
   `ASSERT_IMPL(a_hue_range, clock, reset, rsp_valid, hue_ff <= HUE_GREEN, "hue beyond green")
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "busy accept")

endmodule
